// ===== hw/rtl/coverage_novelty_check_defines.svh =====
// assertion macros for the checker file
`ifndef COVERAGE_NOVELTY_CHECK_DEFINES_SVH
`define COVERAGE_NOVELTY_CHECK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CNC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cnc_pkg.sv =====
package cnc_pkg;

	localparam int unsigned IDX_W   = 13;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LANES   = WORD_W / BYTE_W;
	localparam int unsigned VERD_W  = 2;
	// largest map that the index field can reach
	localparam int unsigned IDX_SPAN = 1 << IDX_W;
	localparam logic [BYTE_W-1:0] BYTE_PRISTINE = '1;

	typedef enum logic {
		REQ_CHECK   = 1'b0,
		REQ_RESTORE = 1'b1
	} req_e;

	typedef enum logic [VERD_W-1:0] {
		VERD_NONE  = 2'd0,
		VERD_HITS  = 2'd1,
		VERD_EDGES = 2'd2
	} verdict_e;

	// what one lane reports about its byte
	typedef struct packed {
		logic [BYTE_W-1:0] bucket;
		logic [BYTE_W-1:0] virgin_next;
		logic              hit;
		logic              fresh;
	} lane_res_t;

	// per-item control carried through stage 1
	typedef struct packed {
		logic restore;
		logic in_range;
		logic last;
	} item_ctl_t;

	// merged result of one item
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] virgin_next;
		verdict_e          verdict;
		logic              verdict_valid;
	} merge_res_t;

	// hit-count bucket of one raw counter
	function automatic logic [BYTE_W-1:0] bucket_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		priority if (b <= 8'd2) begin
			r = b;
		end else if (b == 8'd3) begin
			r = 8'd4;
		end else if (b <= 8'd7) begin
			r = 8'd8;
		end else if (b <= 8'd15) begin
			r = 8'd16;
		end else if (b <= 8'd31) begin
			r = 8'd32;
		end else if (b <= 8'd127) begin
			r = 8'd64;
		end else begin
			r = 8'd128;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/cnc_if.sv =====
// request channel: one trace word or one restore
interface cnc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [cnc_pkg::IDX_W-1:0]   word_index;
	logic [cnc_pkg::WORD_W-1:0]  trace_word;
	logic                        last_word;

	modport source (output valid, req_type, word_index, trace_word, last_word, input ready);
	modport sink (input valid, req_type, word_index, trace_word, last_word, output ready);
endinterface

// result channel: bucketed word and run verdict
interface cnc_res_if;
	logic                        valid;
	logic                        ready;
	logic [cnc_pkg::WORD_W-1:0]  bucketed_word;
	logic [cnc_pkg::VERD_W-1:0]  verdict;
	logic                        verdict_valid;

	modport source (output valid, bucketed_word, verdict, verdict_valid, input ready);
	modport sink (input valid, bucketed_word, verdict, verdict_valid, output ready);
endinterface

// ===== hw/rtl/cnc_ram.sv =====
module cnc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/cnc_lane.sv =====
module cnc_lane (
	input  logic [cnc_pkg::BYTE_W-1:0] raw,
	input  logic [cnc_pkg::BYTE_W-1:0] vir,
	output cnc_pkg::lane_res_t         res
);
	import cnc_pkg::*;

	logic [BYTE_W-1:0] bkt;

	// bucket the counter and test it against the virgin byte
	always_comb begin
		bkt             = bucket_byte(raw);
		res.bucket      = bkt;
		res.virgin_next = vir & ~bkt;
		res.hit         = |(bkt & vir);
		res.fresh       = (bkt != '0) && (vir == BYTE_PRISTINE);
	end

endmodule

// ===== hw/rtl/cnc_merge.sv =====
module cnc_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    fire,
	input  cnc_pkg::item_ctl_t                      ctl,
	input  cnc_pkg::lane_res_t [cnc_pkg::LANES-1:0] lanes,
	output cnc_pkg::merge_res_t                     res
);
	import cnc_pkg::*;

	verdict_e run_q;
	verdict_e run_next;
	logic     any_hit;
	logic     any_fresh;

	// combine lane findings, then the running verdict including this word
	always_comb begin
		any_hit   = 1'b0;
		any_fresh = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			res.word[k*BYTE_W +: BYTE_W]        = lanes[k].bucket;
			res.virgin_next[k*BYTE_W +: BYTE_W] = lanes[k].virgin_next;
			any_hit   = any_hit | lanes[k].hit;
			any_fresh = any_fresh | lanes[k].fresh;
		end
		if (ctl.restore) begin
			res.word = '0;
		end
		run_next = run_q;
		if (!ctl.restore && ctl.in_range && any_hit && run_q != VERD_EDGES) begin
			run_next = any_fresh ? VERD_EDGES : VERD_HITS;
		end
		res.verdict_valid = !ctl.restore && ctl.last;
		res.verdict       = res.verdict_valid ? run_next : VERD_NONE;
	end

	// hold the verdict across a run, clear it on the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= VERD_NONE;
		end else if (fire && !ctl.restore) begin
			run_q <= ctl.last ? VERD_NONE : run_next;
		end
	end

endmodule

// ===== hw/rtl/coverage_novelty_check.sv =====
// Coverage novelty check. Each request carries one 64-bit trace word (eight
// hit counters) or a restore of one virgin word. The eight counters are
// bucketed by eight lanes in parallel, compared with the virgin word read
// from an on-chip memory, and the merged result updates the virgin word and
// the running verdict, which is reported and cleared with the last word of a
// run. The block takes one request per cycle unless the result side stalls;
// each result passes the stage 1 and output registers. A request to the index
// that the item ahead of it is writing back gets the new value by forwarding,
// so back-to-back words to one index are fine. The virgin memory holds
// min(MAP_WORDS, 8192) words and after reset is set to all ones by a clearing
// pass, one word per cycle through the memory's single write port; ready stays
// low until the pass is done. Indexes at or above MAP_WORDS write no memory.
module coverage_novelty_check #(
	parameter int unsigned MAP_WORDS = 8192
) (
	input  logic      clk,
	input  logic      arst_n,
	cnc_req_if.sink   req,
	cnc_res_if.source res
);
	import cnc_pkg::*;

	localparam int unsigned DEPTH = (MAP_WORDS > IDX_SPAN) ? IDX_SPAN : MAP_WORDS;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	logic              accept;
	logic              adv_s1;
	logic              fire_s1;
	logic              in_range;

	logic              clr_busy_q;
	logic [AW-1:0]     clr_q;

	logic              valid_s1;
	item_ctl_t         ctl_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WORD_W-1:0] trace_s1;
	logic              fwd_hit_s1;
	logic [WORD_W-1:0] fwd_data_s1;
	logic [WORD_W-1:0] rdata_s1;
	logic [WORD_W-1:0] vir_s1;

	logic              wr_en_s1;
	logic [WORD_W-1:0] wr_data_s1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;

	lane_res_t [LANES-1:0] lanes;
	merge_res_t            mres;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	verdict_e          out_verdict_q;
	logic              out_vvalid_q;

	// handshake and stage advance
	assign adv_s1    = !out_valid_q || res.ready;
	assign fire_s1   = valid_s1 && adv_s1;
	assign req.ready = !clr_busy_q && (!valid_s1 || adv_s1);
	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.word_index) < MAP_WORDS;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == CLR_LAST) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// write back of stage 1
	assign wr_en_s1   = fire_s1 && ctl_s1.in_range;
	assign wr_data_s1 = ctl_s1.restore ? '1 : mres.virgin_next;

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '1;
		end else begin
			ram_we    = wr_en_s1;
			ram_waddr = idx_s1[AW-1:0];
			ram_wdata = wr_data_s1;
		end
	end

	cnc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (req.word_index[AW-1:0]),
		.rdata (rdata_s1)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, forward the word being written to a same-index follower
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.restore  <= req.req_type == REQ_RESTORE;
			ctl_s1.in_range <= in_range;
			ctl_s1.last     <= req.last_word;
			idx_s1          <= req.word_index;
			trace_s1        <= req.trace_word;
			fwd_hit_s1      <= wr_en_s1 && (idx_s1 == req.word_index);
			fwd_data_s1     <= wr_data_s1;
		end
	end

	assign vir_s1 = fwd_hit_s1 ? fwd_data_s1 : rdata_s1;

	// one lane per counter byte
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cnc_lane u_lane (
			.raw (trace_s1[g*BYTE_W +: BYTE_W]),
			.vir (vir_s1[g*BYTE_W +: BYTE_W]),
			.res (lanes[g])
		);
	end

	cnc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.ctl    (ctl_s1),
		.lanes  (lanes),
		.res    (mres)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_word_q    <= mres.word;
			out_verdict_q <= mres.verdict;
			out_vvalid_q  <= mres.verdict_valid;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.bucketed_word = out_word_q;
	assign res.verdict       = out_verdict_q;
	assign res.verdict_valid = out_vvalid_q;

endmodule

// ===== hw/rtl/cnc_checker.sv =====
`include "coverage_novelty_check_defines.svh"

module cnc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [cnc_pkg::WORD_W-1:0]  bucketed_word,
	input logic [cnc_pkg::VERD_W-1:0]  verdict,
	input logic                        verdict_valid
);
	import cnc_pkg::*;

	logic                       shape_ok;
	logic                       res_stalled;
	logic [WORD_W+VERD_W:0]     res_bus;

	// every byte of the result word is zero or a single power of two
	always_comb begin
		shape_ok = 1'b1;
		for (int k = 0; k < LANES; k++) begin
			shape_ok = shape_ok && $onehot0(bucketed_word[k*BYTE_W +: BYTE_W]);
		end
	end

	assign res_stalled = res_valid && !res_ready;
	assign res_bus     = {bucketed_word, verdict, verdict_valid};

	// a stalled result holds
	`CNC_ASSERT_NEXT(a_res_hold, res_stalled, res_valid && $stable(res_bus), "stalled result changed")

	// every bucketed byte is a bucket code
	`CNC_ASSERT_NOW(a_bucket_shape, res_valid, shape_ok, "bucketed byte not a bucket")

	// a verdict only appears when it closes a run
	`CNC_ASSERT_NOW(a_verdict_gated, res_valid && !verdict_valid, verdict == VERD_NONE, "verdict outside run end")

	// verdict stays within its codes
	`CNC_ASSERT_NOW(a_verdict_range, res_valid, verdict <= VERD_EDGES, "verdict code out of range")

endmodule

bind coverage_novelty_check cnc_checker u_cnc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.bucketed_word (res.bucketed_word),
	.verdict       (res.verdict),
	.verdict_valid (res.verdict_valid)
);

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cnc_pkg::*;

	localparam int unsigned MAP_WORDS  = 8192;
	localparam int unsigned ITEMS      = 1300;
	localparam int unsigned TAIL_ITEMS = 150;
	localparam int unsigned DRAIN_AT   = 700;
	localparam int unsigned HOLD_AT    = 400;
	localparam int unsigned HOLD_LEN   = 80;
	localparam int unsigned SETTLE     = 20;
	localparam int unsigned PRINT_CAP  = 50;
	localparam longint unsigned LIMIT_NS = 64'd3_000_000;

	typedef struct {
		req_e              kind;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] trace;
		logic              last;
		bit                drain;
	} trace_req_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		verdict_e          verdict;
		logic              closes;
	} novelty_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cnc_req_if req_ch ();
	cnc_res_if res_ch ();

	coverage_novelty_check #(
		.MAP_WORDS(MAP_WORDS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.res   (res_ch.source)
	);

	// request side drive registers
	logic              drv_valid = 1'b0;
	req_e              drv_kind = REQ_CHECK;
	logic [IDX_W-1:0]  drv_idx = '0;
	logic [WORD_W-1:0] drv_trace = '0;
	logic              drv_last = 1'b0;
	logic              sink_ready = 1'b0;

	assign req_ch.valid      = drv_valid;
	assign req_ch.req_type   = drv_kind;
	assign req_ch.word_index = drv_idx;
	assign req_ch.trace_word = drv_trace;
	assign req_ch.last_word  = drv_last;
	assign res_ch.ready      = sink_ready;

	// pending requests, awaited results and the predictor's copy of the state
	trace_req_t        send_q[$];
	novelty_res_t      awaited[$];
	logic [WORD_W-1:0] virgin_copy [IDX_SPAN];
	verdict_e          run_verdict = VERD_NONE;
	trace_req_t        on_bus;
	novelty_res_t      want;
	int unsigned       fail_count = 0;
	int unsigned       sent_count = 0;
	int unsigned       results_seen = 0;
	logic [IDX_W-1:0]  hot_idx [12];

	// clock and reset
	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < IDX_SPAN; i++) begin
			virgin_copy[i] = '1;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] exp_val);
		if (fail_count < PRINT_CAP) begin
			$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp_val);
		end
		fail_count++;
	endtask

	// hit-count class of one raw counter
	function automatic logic [BYTE_W-1:0] count_class(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		if (c < 8'd3) begin
			r = c;
		end else if (c[7]) begin
			r = 8'h80;
		end else if (c[6] | c[5]) begin
			r = 8'h40;
		end else begin
			r = '0;
			// the highest set bit wins: next power of two above it
			for (int k = 0; k < 5; k++) begin
				if (c[k]) r = 8'd1 << (k + 1);
			end
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] class_word(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int k = 0; k < LANES; k++) begin
			r[k*BYTE_W +: BYTE_W] = count_class(w[k*BYTE_W +: BYTE_W]);
		end
		return r;
	endfunction

	// novelty prediction for one accepted request
	function automatic void predict_novelty(input trace_req_t it);
		novelty_res_t      r;
		logic [WORD_W-1:0] cur;
		logic [WORD_W-1:0] vir;
		logic              fresh;
		r.word = '0;
		r.verdict = VERD_NONE;
		r.closes = 1'b0;
		if (it.kind == REQ_RESTORE) begin
			if (it.idx < MAP_WORDS) virgin_copy[it.idx] = '1;
		end else begin
			cur = class_word(it.trace);
			if (it.idx < MAP_WORDS) begin
				vir = virgin_copy[it.idx];
				if (cur != '0 && (cur & vir) != '0) begin
					if (run_verdict != VERD_EDGES) begin
						fresh = 1'b0;
						for (int k = 0; k < LANES; k++) begin
							if (cur[k*BYTE_W +: BYTE_W] != '0 &&
									vir[k*BYTE_W +: BYTE_W] == BYTE_PRISTINE) begin
								fresh = 1'b1;
							end
						end
						run_verdict = fresh ? VERD_EDGES : VERD_HITS;
					end
					virgin_copy[it.idx] = vir & ~cur;
				end
			end
			r.word = cur;
			if (it.last) begin
				r.verdict = run_verdict;
				r.closes = 1'b1;
				run_verdict = VERD_NONE;
			end
		end
		awaited.push_back(r);
	endfunction

	// stimulus helpers
	task automatic add_req(input req_e kind, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] trace, input logic last, input bit drain);
		trace_req_t it;
		it.kind = kind;
		it.idx = idx;
		it.trace = trace;
		it.last = last;
		it.drain = drain || (send_q.size() == DRAIN_AT);
		send_q.push_back(it);
	endtask

	function automatic logic [BYTE_W-1:0] rand_counter();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45) return '0;
		if (p < 75) return BYTE_W'($urandom_range(1, 7));
		if (p < 88) return BYTE_W'($urandom_range(8, 31));
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [WORD_W-1:0] rand_trace();
		logic [WORD_W-1:0] w;
		if ($urandom_range(0, 9) == 0) begin
			w = {$urandom, $urandom};
		end else begin
			for (int k = 0; k < LANES; k++) begin
				w[k*BYTE_W +: BYTE_W] = rand_counter();
			end
		end
		return w;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		if ($urandom_range(0, 99) < 75) return hot_idx[$urandom_range(0, 11)];
		return IDX_W'($urandom_range(0, IDX_SPAN - 1));
	endfunction

	// fill the request queue: directed part, then random trace runs
	initial begin
		int unsigned run_len;
		bit          broken;
		logic        lw;
		hot_idx[0] = '0;
		hot_idx[1] = IDX_W'(IDX_SPAN - 1);
		for (int i = 2; i < 12; i++) begin
			hot_idx[i] = IDX_W'($urandom_range(0, IDX_SPAN - 1));
		end

		// empty run, every bucket boundary, repeat hits
		add_req(REQ_CHECK, 13'd0, '0, 1'b1, 0);
		add_req(REQ_CHECK, 13'd0, 64'hff80_7f20_1f10_0f08, 1'b0, 0);
		add_req(REQ_CHECK, 13'd0, 64'h0704_0302_0100_4021, 1'b1, 0);
		add_req(REQ_CHECK, 13'd0, 64'hff80_7f20_1f10_0f08, 1'b1, 0);
		add_req(REQ_CHECK, 13'd0, 64'h0101_0101_0101_0101, 1'b1, 0);
		// restore ignores trace and last, then fresh edges again
		add_req(REQ_RESTORE, 13'd0, '1, 1'b1, 1);
		add_req(REQ_CHECK, 13'd0, 64'h0101_0101_0101_0101, 1'b0, 0);
		add_req(REQ_CHECK, 13'd0, 64'h0202_0202_0202_0202, 1'b1, 0);
		// top index, saturated counters
		add_req(REQ_CHECK, 13'h1fff, '1, 1'b0, 0);
		add_req(REQ_CHECK, 13'h1fff, '1, 1'b1, 0);
		add_req(REQ_CHECK, 13'h1fff, 64'h8000_0000_0000_0000, 1'b1, 0);
		// consecutive words to one index
		add_req(REQ_CHECK, 13'd5, 64'h0000_0000_0000_0003, 1'b0, 0);
		add_req(REQ_CHECK, 13'd5, 64'h0000_0000_0000_0300, 1'b0, 0);
		add_req(REQ_CHECK, 13'd5, 64'h0000_0000_0000_0003, 1'b0, 0);
		add_req(REQ_CHECK, 13'd5, 64'h0c0c_0c0c_0c0c_0c0c, 1'b1, 0);
		add_req(REQ_RESTORE, 13'h1fff, '0, 1'b0, 0);
		add_req(REQ_CHECK, 13'h1fff, '1, 1'b1, 0);
		// restore of a word never touched, alternating bit patterns
		add_req(REQ_RESTORE, 13'd4095, {$urandom, $urandom}, 1'b1, 0);
		add_req(REQ_CHECK, 13'd4096, 64'h5555_aaaa_5555_aaaa, 1'b1, 0);
		add_req(REQ_CHECK, 13'd2730, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 0);
		add_req(REQ_CHECK, 13'd1, '0, 1'b1, 0);

		// random runs, a few with stray last flags
		while (send_q.size() < ITEMS) begin
			run_len = $urandom_range(1, 10);
			broken = ($urandom_range(0, 9) == 0);
			for (int j = 0; j < run_len; j++) begin
				if ($urandom_range(0, 99) < 8) begin
					add_req(REQ_RESTORE, pick_index(), {$urandom, $urandom},
						1'($urandom_range(0, 1)), 0);
				end else begin
					lw = broken ? ($urandom_range(0, 3) == 0) : (j == run_len - 1);
					add_req(REQ_CHECK, pick_index(), rand_trace(), lw, 0);
				end
			end
		end
	end

	// request driver
	int unsigned gap_left = 0;
	int unsigned idle_pct_tx = 20;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			// transfer accepted: predict its result
			if (drv_valid && req_ch.ready) begin
				predict_novelty(on_bus);
				sent_count++;
				if (sent_count % 128 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct_tx = 0;
						1: idle_pct_tx = 15;
						default: idle_pct_tx = 40;
					endcase
				end
			end
			if (!drv_valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (send_q.size() == 0) begin
					drv_valid <= 1'b0;
				end else if (send_q[0].drain && awaited.size() != 0) begin
					drv_valid <= 1'b0;
				end else begin
					on_bus = send_q.pop_front();
					drv_kind <= on_bus.kind;
					drv_idx <= on_bus.idx;
					drv_trace <= on_bus.trace;
					drv_last <= on_bus.last;
					drv_valid <= 1'b1;
					if (send_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < idle_pct_tx) begin
						gap_left = $urandom_range(1, 4);
					end
				end
			end
		end
	end

	// result monitor and receiver stalls
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 0;
	int unsigned idle_pct_rx = 20;

	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			// transfer on the result side: compare with the oldest expectation
			if (res_ch.valid && sink_ready) begin
				results_seen++;
				if (results_seen % 128 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct_rx = 0;
						1: idle_pct_rx = 15;
						default: idle_pct_rx = 40;
					endcase
				end
				if (awaited.size() == 0) begin
					report_mismatch("result with nothing awaited", res_ch.bucketed_word, '0);
				end else begin
					want = awaited.pop_front();
					if (res_ch.bucketed_word !== want.word)
						report_mismatch("bucketed_word", res_ch.bucketed_word, want.word);
					if (res_ch.verdict !== want.verdict)
						report_mismatch("verdict", WORD_W'(res_ch.verdict), WORD_W'(want.verdict));
					if (res_ch.verdict_valid !== want.closes)
						report_mismatch("verdict_valid", WORD_W'(res_ch.verdict_valid),
							WORD_W'(want.closes));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				sink_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				// long hold-off so the pipeline backs up into the request side
				hold_done = 1;
				hold_left = HOLD_LEN;
				sink_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				sink_ready <= 1'b0;
			end else if (send_q.size() >= TAIL_ITEMS && $urandom_range(0, 99) < idle_pct_rx) begin
				stall_left = $urandom_range(0, 3);
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= 1'b1;
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		while (!(send_q.size() == 0 && !drv_valid && awaited.size() == 0)) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (awaited.size() != 0)
			report_mismatch("results never returned", WORD_W'(awaited.size()), '0);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== coverage_novelty_check.f =====
+incdir+hw/rtl
hw/rtl/cnc_pkg.sv
hw/rtl/cnc_if.sv
hw/rtl/cnc_ram.sv
hw/rtl/cnc_lane.sv
hw/rtl/cnc_merge.sv
hw/rtl/coverage_novelty_check.sv
hw/rtl/cnc_checker.sv
bench/tb_top.sv
